// ===== hw/rtl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants of the ready-queue scheduler
// Field widths, operation and status codes, and the structs that pass
// between the request stage, the ready lists and the result stage.
// ----------------------------------------------------------------------------
package prq_pkg;

	// sizes of the task and priority spaces (field widths follow from them)
	localparam int TASK_COUNT      = 32;
	localparam int PRIORITY_LEVELS = 32;
	localparam int TASK_W          = $clog2(TASK_COUNT);
	localparam int PRIO_W          = $clog2(PRIORITY_LEVELS);

	localparam logic [TASK_W-1:0] IDLE_TASK = '0;

	// request operation codes; the fourth code is unused
	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_SCHEDULE = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_IDLE_REMOVE   = 2'd1,
		ST_ALREADY_READY = 2'd2,
		ST_NOT_READY     = 2'd3
	} status_t;

	// one request as held in the input register
	typedef struct packed {
		logic [1:0]        opcode;
		logic [TASK_W-1:0] task_id;
		logic [PRIO_W-1:0] task_priority;
		logic              in_isr;
	} req_t;

	// ready view after a request has been applied to the lists
	typedef struct packed {
		status_t           status;
		logic [TASK_W-1:0] next_task;
		logic [PRIO_W-1:0] highest_priority;
		logic              any_ready;
	} view_t;

	// one result as held in the result register
	typedef struct packed {
		view_t view;
		logic  switch_needed;
	} res_t;

endpackage

// ===== hw/rtl/prq_prio_enc.sv =====
// ----------------------------------------------------------------------------
// prq_prio_enc: highest set level of the ready bitmap
// Returns the index of the most significant set bit and whether any is set.
// ----------------------------------------------------------------------------
module prq_prio_enc (
	input  logic [prq_pkg::PRIORITY_LEVELS-1:0] bitmap,
	output logic [prq_pkg::PRIO_W-1:0]          level,
	output logic                                any_set
);
	import prq_pkg::*;

	// scan upward, last set bit wins
	always_comb begin
		level = '0;
		for (int i = 0; i < PRIORITY_LEVELS; i++) begin
			if (bitmap[i]) begin
				level = PRIO_W'(i);
			end
		end
		any_set = |bitmap;
	end

endmodule

// ===== hw/rtl/prq_ready_lists.sv =====
// ----------------------------------------------------------------------------
// prq_ready_lists: per-priority FIFO ready lists and the ready bitmap
// Applies one add or remove per cycle, when fire is high, to the doubly linked
// lists and returns the ready view (status, head of highest level) after it.
// ----------------------------------------------------------------------------
module prq_ready_lists (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  prq_pkg::req_t  req,
	output prq_pkg::view_t view
);
	import prq_pkg::*;

	// link arrays, written before they are read
	logic [TASK_W-1:0] head_q  [PRIORITY_LEVELS];
	logic [TASK_W-1:0] tail_q  [PRIORITY_LEVELS];
	logic [TASK_W-1:0] next_q  [TASK_COUNT];
	logic [TASK_W-1:0] prev_q  [TASK_COUNT];
	logic [PRIO_W-1:0] prio_q  [TASK_COUNT];

	// per-task and per-level bits
	logic [PRIORITY_LEVELS-1:0] bitmap_q, bitmap_n;
	logic [TASK_COUNT-1:0]      ready_q, ready_n;
	logic [TASK_COUNT-1:0]      is_head_q, is_head_n;
	logic [TASK_COUNT-1:0]      is_tail_q, is_tail_n;

	// single write port per array
	logic              head_we, tail_we, next_we, prev_we, prio_we;
	logic [PRIO_W-1:0] head_wa, tail_wa;
	logic [TASK_W-1:0] next_wa, prev_wa;
	logic [TASK_W-1:0] head_wd, tail_wd, next_wd, prev_wd;
	logic [PRIO_W-1:0] prio_wd;

	// reads at the request's task and level
	logic [TASK_W-1:0] t;
	logic [PRIO_W-1:0] p;
	logic [PRIO_W-1:0] t_prio;
	logic [TASK_W-1:0] t_next, t_prev, p_tail;
	status_t           status;

	logic [PRIO_W-1:0] top_level;
	logic              top_any;

	assign t      = req.task_id;
	assign p      = req.task_priority;
	assign t_prio = prio_q[t];
	assign t_next = next_q[t];
	assign t_prev = prev_q[t];
	assign p_tail = tail_q[p];

	// list update for add and remove
	always_comb begin
		bitmap_n  = bitmap_q;
		ready_n   = ready_q;
		is_head_n = is_head_q;
		is_tail_n = is_tail_q;
		head_we = 1'b0; head_wa = p; head_wd = t;
		tail_we = 1'b0; tail_wa = p; tail_wd = t;
		next_we = 1'b0; next_wa = p_tail; next_wd = t;
		prev_we = 1'b0; prev_wa = t; prev_wd = p_tail;
		prio_we = 1'b0; prio_wd = p;
		status  = ST_OK;
		case (op_t'(req.opcode))
			OP_ADD: begin
				if (ready_q[t]) begin
					status = ST_ALREADY_READY;
				end else if (fire) begin
					prio_we      = 1'b1;
					ready_n[t]   = 1'b1;
					tail_we      = 1'b1;
					is_tail_n[t] = 1'b1;
					if (bitmap_q[p]) begin
						// append behind the current tail
						next_we           = 1'b1;
						prev_we           = 1'b1;
						is_tail_n[p_tail] = 1'b0;
						is_head_n[t]      = 1'b0;
					end else begin
						// first task of this level
						head_we      = 1'b1;
						is_head_n[t] = 1'b1;
						bitmap_n[p]  = 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				if (t == IDLE_TASK) begin
					status = ST_IDLE_REMOVE;
				end else if (!ready_q[t]) begin
					status = ST_NOT_READY;
				end else if (fire) begin
					ready_n[t] = 1'b0;
					if (is_head_q[t] && is_tail_q[t]) begin
						bitmap_n[t_prio] = 1'b0;
					end else if (is_head_q[t]) begin
						head_we           = 1'b1;
						head_wa           = t_prio;
						head_wd           = t_next;
						is_head_n[t_next] = 1'b1;
					end else if (is_tail_q[t]) begin
						tail_we           = 1'b1;
						tail_wa           = t_prio;
						tail_wd           = t_prev;
						is_tail_n[t_prev] = 1'b1;
					end else begin
						// unlink from the middle
						next_we = 1'b1;
						next_wa = t_prev;
						next_wd = t_next;
						prev_we = 1'b1;
						prev_wa = t_next;
						prev_wd = t_prev;
					end
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q  <= '0;
			ready_q   <= '0;
			is_head_q <= '0;
			is_tail_q <= '0;
		end else begin
			bitmap_q  <= bitmap_n;
			ready_q   <= ready_n;
			is_head_q <= is_head_n;
			is_tail_q <= is_tail_n;
		end
	end

	// link arrays
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_q[head_wa] <= head_wd;
		end
		if (tail_we) begin
			tail_q[tail_wa] <= tail_wd;
		end
		if (next_we) begin
			next_q[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_q[prev_wa] <= prev_wd;
		end
		if (prio_we) begin
			prio_q[t] <= prio_wd;
		end
	end

	// highest level after the update
	prq_prio_enc u_prio_enc (
		.bitmap  (bitmap_n),
		.level   (top_level),
		.any_set (top_any)
	);

	// head of that level, forwarding this cycle's head write
	always_comb begin
		view.status           = status;
		view.highest_priority = top_level;
		view.any_ready        = top_any;
		if (!top_any) begin
			view.next_task = '0;
		end else if (head_we && head_wa == top_level) begin
			view.next_task = head_wd;
		end else begin
			view.next_task = head_q[top_level];
		end
	end

endmodule

// ===== hw/rtl/priority_ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler: bitmap priority scheduler, FIFO ready lists
// Add, remove and schedule requests on per-priority ready lists; schedule
// picks the head of the highest ready level and may make it current.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    opcode task_id task_priority in_isr
//   out      from block out_valid / out_stall  status next_task highest_priority
//                                              switch_needed any_ready
//   cfg      to block   cfg_valid / cfg_ready  scheduler_enabled
//
// One request enters per cycle while in_stall is low. Each request passes the
// input register, where the list update is applied, and then the result
// register, from which its result leaves on the out channel.
// Reset clears the ready bitmap, ready bits, current task and enable; the link
// arrays need no clearing pass. A stalled result holds the input register, so
// in_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic [prq_pkg::TASK_W-1:0] task_id,
	input  logic [prq_pkg::PRIO_W-1:0] task_priority,
	input  logic                       in_isr,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [prq_pkg::TASK_W-1:0] next_task,
	output logic [prq_pkg::PRIO_W-1:0] highest_priority,
	output logic                       switch_needed,
	output logic                       any_ready,
	// configuration
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       scheduler_enabled
);
	import prq_pkg::*;

	req_t              req_s1;
	logic              vld_s1;
	res_t              res_s2;
	logic              vld_s2;
	logic [TASK_W-1:0] current_task_q;
	logic              sched_en_q;

	logic  advance, fire, accept;
	view_t view;
	logic  is_sched, sw;

	// handshake
	assign advance   = !vld_s2 || !out_stall;
	assign fire      = vld_s1 && advance;
	assign in_stall  = vld_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= '{opcode: opcode, task_id: task_id,
			            task_priority: task_priority, in_isr: in_isr};
		end
	end

	// list update
	prq_ready_lists u_lists (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.view   (view)
	);

	// switch decision against the task current before this request
	assign is_sched = (op_t'(req_s1.opcode) == OP_SCHEDULE) && view.any_ready;
	assign sw       = is_sched && (view.next_task != current_task_q);

	// current task and enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_task_q <= IDLE_TASK;
			sched_en_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sched_en_q <= scheduler_enabled;
			end
			if (fire && is_sched && sched_en_q && !req_s1.in_isr) begin
				current_task_q <= view.next_task;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fire) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= '{view: view, switch_needed: sw};
		end
	end

	assign out_valid        = vld_s2;
	assign status           = res_s2.view.status;
	assign next_task        = res_s2.view.next_task;
	assign highest_priority = res_s2.view.highest_priority;
	assign switch_needed    = res_s2.switch_needed;
	assign any_ready        = res_s2.view.any_ready;

endmodule

// ===== sim/priority_ready_queue_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_tb: self-checking bench for the ready-queue scheduler
// A short table of directed requests covers empty lists, idle task removal,
// double add, removal of a task that is not ready, the unused opcode, head,
// middle and tail unlinks, and switch suppression from interrupt context.
// After it come random request streams under several idle and stall mixes.
// Every result is checked against a local model of the lists or a typed table result.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_tb;
	import prq_pkg::*;

	localparam int         RESET_CYCLES = 10;
	localparam int         RAND_ITEMS   = 1300;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         MAX_REPORTS  = 10;
	localparam int         DRAIN_CYCLES = 8;
	localparam logic [1:0] OP_UNUSED    = 2'd3;

	// directed table row: either a register write or one request
	typedef struct {
		logic              is_cfg;
		logic              en;
		logic [1:0]        op;
		logic [TASK_W-1:0] id;
		logic [PRIO_W-1:0] prio;
		logic              isr;
		logic              typed;
		res_t              res;
	} dir_row_t;

	logic                clk               = 1'b0;
	logic                arst_n            = 1'b0;
	logic                in_valid          = 1'b0;
	logic                in_stall;
	logic [1:0]          opcode            = '0;
	logic [TASK_W-1:0]   task_id           = '0;
	logic [PRIO_W-1:0]   task_priority     = '0;
	logic                in_isr            = 1'b0;
	logic                out_valid;
	logic                out_stall         = 1'b0;
	logic [1:0]          status;
	logic [TASK_W-1:0]   next_task;
	logic [PRIO_W-1:0]   highest_priority;
	logic                switch_needed;
	logic                any_ready;
	logic                cfg_valid         = 1'b0;
	logic                cfg_ready;
	logic                scheduler_enabled = 1'b0;

	// local copy of the scheduler state
	logic [PRIORITY_LEVELS-1:0] lvl_map;
	logic [TASK_W-1:0]          lvl_head  [PRIORITY_LEVELS];
	logic [TASK_W-1:0]          lvl_tail  [PRIORITY_LEVELS];
	logic [TASK_W-1:0]          link_next [TASK_COUNT];
	logic [TASK_W-1:0]          link_prev [TASK_COUNT];
	logic [PRIO_W-1:0]          task_lvl  [TASK_COUNT];
	logic                       rdy       [TASK_COUNT];
	logic [TASK_W-1:0]          cur_task;
	logic                       sched_en;
	int                         ready_cnt;

	res_t     pending_res [$];
	dir_row_t dir_tab     [$];
	int       idle_pct  = 0;
	int       stall_pct = 0;
	int       fail_cnt  = 0;
	int       cycle_cnt = 0;

	priority_ready_queue_scheduler u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.task_id          (task_id),
		.task_priority    (task_priority),
		.in_isr           (in_isr),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.next_task        (next_task),
		.highest_priority (highest_priority),
		.switch_needed    (switch_needed),
		.any_ready        (any_ready),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.scheduler_enabled(scheduler_enabled)
	);

	always #2 clk = ~clk;

	// append at the tail of the task's level
	function automatic status_t list_add(logic [TASK_W-1:0] t, logic [PRIO_W-1:0] p);
		if (int'(t) >= TASK_COUNT) return ST_NOT_READY;
		if (rdy[t]) return ST_ALREADY_READY;
		if (int'(p) >= PRIORITY_LEVELS) p = PRIO_W'(PRIORITY_LEVELS - 1);
		task_lvl[t] = p;
		if (lvl_map[p]) begin
			link_next[lvl_tail[p]] = t;
			link_prev[t]           = lvl_tail[p];
		end else begin
			lvl_head[p] = t;
			lvl_map[p]  = 1'b1;
		end
		lvl_tail[p] = t;
		rdy[t]      = 1'b1;
		ready_cnt++;
		return ST_OK;
	endfunction

	// unlink from any position of its level
	function automatic status_t list_remove(logic [TASK_W-1:0] t);
		logic [PRIO_W-1:0] p;
		if (t == IDLE_TASK) return ST_IDLE_REMOVE;
		if (int'(t) >= TASK_COUNT || !rdy[t]) return ST_NOT_READY;
		p = task_lvl[t];
		if (lvl_head[p] == t && lvl_tail[p] == t) begin
			lvl_map[p] = 1'b0;
		end else if (lvl_head[p] == t) begin
			lvl_head[p] = link_next[t];
		end else if (lvl_tail[p] == t) begin
			lvl_tail[p] = link_prev[t];
		end else begin
			link_next[link_prev[t]] = link_next[t];
			link_prev[link_next[t]] = link_prev[t];
		end
		rdy[t] = 1'b0;
		ready_cnt--;
		return ST_OK;
	endfunction

	// apply one request and return the result it should give
	function automatic res_t sched_apply(logic [1:0] op, logic [TASK_W-1:0] t,
			logic [PRIO_W-1:0] p, logic isr);
		res_t r;
		r             = '0;
		r.view.status = ST_OK;
		if (op == OP_ADD) r.view.status = list_add(t, p);
		else if (op == OP_REMOVE) r.view.status = list_remove(t);
		for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
			if (lvl_map[l] && !r.view.any_ready) begin
				r.view.any_ready        = 1'b1;
				r.view.highest_priority = l[PRIO_W-1:0];
				r.view.next_task        = lvl_head[l];
			end
		end
		if (op == OP_SCHEDULE && r.view.any_ready) begin
			r.switch_needed = (r.view.next_task != cur_task);
			if (sched_en && !isr) cur_task = r.view.next_task;
		end
		return r;
	endfunction

	function automatic res_t mk_res(status_t st, logic [TASK_W-1:0] nt,
			logic [PRIO_W-1:0] hp, logic sw, logic any);
		res_t r;
		r.view.status           = st;
		r.view.next_task        = nt;
		r.view.highest_priority = hp;
		r.view.any_ready        = any;
		r.switch_needed         = sw;
		return r;
	endfunction

	function automatic void tab_req(logic [1:0] op, logic [TASK_W-1:0] id,
			logic [PRIO_W-1:0] prio, logic isr, logic typed, res_t res);
		dir_row_t row;
		row = '{1'b0, 1'b0, op, id, prio, isr, typed, res};
		dir_tab.push_back(row);
	endfunction

	function automatic void tab_cfg(logic en);
		dir_row_t row;
		row = '{1'b1, en, OP_ADD, '0, '0, 1'b0, 1'b0, '0};
		dir_tab.push_back(row);
	endfunction

	// random task that is (or is not) on a ready list
	function automatic logic [TASK_W-1:0] pick_task(logic want_ready);
		logic [TASK_W-1:0] cand [$];
		for (int i = 0; i < TASK_COUNT; i++)
			if (rdy[i] == want_ready) cand.push_back(i[TASK_W-1:0]);
		if (cand.size() == 0) return TASK_W'($urandom);
		return cand[$urandom_range(cand.size() - 1)];
	endfunction

	// present one request after a random gap, record its result on accept
	task automatic send_req(input logic [1:0] op, input logic [TASK_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input logic isr,
			input logic typed, input res_t typed_res);
		res_t pred;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		opcode        <= op;
		task_id       <= id;
		task_priority <= prio;
		in_isr        <= isr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = sched_apply(op, id, prio, isr);
		pending_res.push_back(typed ? typed_res : pred);
	endtask

	// mostly well-formed requests: adds of idle tasks, removes of ready ones
	task automatic send_random();
		int                r;
		logic [1:0]        op;
		logic [TASK_W-1:0] t;
		logic [PRIO_W-1:0] p;
		r = $urandom_range(99);
		t = TASK_W'($urandom);
		if (r < 5) op = OP_UNUSED;
		else if (r < 25) op = OP_SCHEDULE;
		else if (int'($urandom_range(TASK_COUNT - 1)) >= ready_cnt) op = OP_ADD;
		else op = OP_REMOVE;
		if (op == OP_ADD && $urandom_range(9) != 0) t = pick_task(1'b0);
		if (op == OP_REMOVE && $urandom_range(9) != 0) t = pick_task(1'b1);
		// crowd a few levels so lists get deep
		if ($urandom_range(3) == 0) p = PRIO_W'($urandom);
		else p = PRIO_W'($urandom_range(3));
		send_req(op, t, p, ($urandom_range(3) == 0), 1'b0, '0);
	endtask

	// let every outstanding result come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input logic en);
		drain();
		cfg_valid         <= 1'b1;
		scheduler_enabled <= en;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sched_en   = en;
	endtask

	// result check and receiver stall
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = mk_res(status_t'(status), next_task, highest_priority,
				switch_needed, any_ready);
			if (pending_res.size() == 0) begin
				if (fail_cnt < MAX_REPORTS)
					$display("unexpected result: st=%0d nt=%0d hp=%0d sw=%0b any=%0b",
						got.view.status, got.view.next_task,
						got.view.highest_priority, got.switch_needed,
						got.view.any_ready);
				fail_cnt++;
			end else begin
				want = pending_res.pop_front();
				if (got !== want) begin
					if (fail_cnt < MAX_REPORTS)
						$display({"mismatch: exp st=%0d nt=%0d hp=%0d sw=%0b any=%0b",
							" got st=%0d nt=%0d hp=%0d sw=%0b any=%0b"},
							want.view.status, want.view.next_task,
							want.view.highest_priority, want.switch_needed,
							want.view.any_ready, got.view.status,
							got.view.next_task, got.view.highest_priority,
							got.switch_needed, got.view.any_ready);
					fail_cnt++;
				end
			end
		end
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("priority_ready_queue_scheduler_tb: FAIL");
			$finish;
		end
	end

	initial begin
		// model reset
		lvl_map   = '0;
		cur_task  = IDLE_TASK;
		sched_en  = 1'b0;
		ready_cnt = 0;
		for (int i = 0; i < TASK_COUNT; i++) rdy[i] = 1'b0;

		// directed table
		tab_cfg(1'b0);
		tab_req(OP_SCHEDULE, 5'd0,  5'd0,  1'b0, 1'b1,
			mk_res(ST_OK, 5'd0, 5'd0, 1'b0, 1'b0));
		tab_req(OP_REMOVE,   5'd0,  5'd0,  1'b0, 1'b1,
			mk_res(ST_IDLE_REMOVE, 5'd0, 5'd0, 1'b0, 1'b0));
		tab_req(OP_REMOVE,   5'd5,  5'd0,  1'b0, 1'b1,
			mk_res(ST_NOT_READY, 5'd0, 5'd0, 1'b0, 1'b0));
		tab_req(OP_UNUSED,   5'd31, 5'd31, 1'b1, 1'b1,
			mk_res(ST_OK, 5'd0, 5'd0, 1'b0, 1'b0));
		tab_req(OP_ADD,      5'd0,  5'd0,  1'b0, 1'b1,
			mk_res(ST_OK, 5'd0, 5'd0, 1'b0, 1'b1));
		tab_req(OP_ADD,      5'd31, 5'd31, 1'b0, 1'b1,
			mk_res(ST_OK, 5'd31, 5'd31, 1'b0, 1'b1));
		tab_req(OP_ADD,      5'd31, 5'd3,  1'b1, 1'b1,
			mk_res(ST_ALREADY_READY, 5'd31, 5'd31, 1'b0, 1'b1));
		tab_req(OP_ADD,      5'd1,  5'd31, 1'b0, 1'b0, '0);
		tab_req(OP_ADD,      5'd2,  5'd31, 1'b0, 1'b0, '0);
		tab_req(OP_SCHEDULE, 5'd0,  5'd0,  1'b0, 1'b0, '0);
		// middle, head, then sole entry
		tab_req(OP_REMOVE,   5'd1,  5'd0,  1'b0, 1'b0, '0);
		tab_req(OP_REMOVE,   5'd31, 5'd0,  1'b0, 1'b0, '0);
		tab_req(OP_REMOVE,   5'd2,  5'd0,  1'b0, 1'b0, '0);
		tab_req(OP_ADD,      5'd7,  5'd30, 1'b0, 1'b0, '0);
		tab_req(OP_ADD,      5'd8,  5'd30, 1'b1, 1'b0, '0);
		tab_req(OP_ADD,      5'd9,  5'd30, 1'b0, 1'b0, '0);
		tab_req(OP_REMOVE,   5'd9,  5'd0,  1'b0, 1'b0, '0);
		// kernel started: ISR suppresses the switch, task context takes it
		tab_cfg(1'b1);
		tab_req(OP_SCHEDULE, 5'd0,  5'd0,  1'b1, 1'b0, '0);
		tab_req(OP_SCHEDULE, 5'd0,  5'd0,  1'b0, 1'b0, '0);
		tab_req(OP_SCHEDULE, 5'd0,  5'd0,  1'b0, 1'b0, '0);
		tab_req(OP_REMOVE,   5'd7,  5'd0,  1'b0, 1'b0, '0);
		tab_req(OP_SCHEDULE, 5'd0,  5'd0,  1'b0, 1'b0, '0);
		tab_req(OP_REMOVE,   5'd8,  5'd0,  1'b0, 1'b0, '0);
		tab_req(OP_SCHEDULE, 5'd0,  5'd0,  1'b0, 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) write_enable(dir_tab[i].en);
			else send_req(dir_tab[i].op, dir_tab[i].id, dir_tab[i].prio,
				dir_tab[i].isr, dir_tab[i].typed, dir_tab[i].res);
		end

		// random streams under different idle and stall mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 72; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 72; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			write_enable(ph != 1);
			repeat (RAND_ITEMS / 4) send_random();
		end

		drain();
		if (fail_cnt == 0) $display("priority_ready_queue_scheduler_tb: PASS");
		else $display("priority_ready_queue_scheduler_tb: FAIL");
		$finish;
	end

endmodule
